>>> rtl/core/gmm_pkg.sv
// ============================================================================
// gmm_pkg
// Shared types, constants and helper functions of the fixed-point
// matrix multiply-accumulate core.
// ============================================================================
`default_nettype none

package gmm_pkg;

  // Largest matrix dimension held in the element stores.
  localparam int MAX_DIM    = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  // Loop counters must hold the dimension itself, not only the last index.
  localparam int DIM_W      = $clog2(MAX_DIM + 1);

  localparam int WORD_W     = 32;
  localparam int CFG_DIM_W  = 5;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Q16.16 one.
  localparam logic signed [WORD_W-1:0] Q_ONE = 32'sd65536;

  // Request opcodes.
  localparam logic [2:0] OP_LOAD_A  = 3'd0;
  localparam logic [2:0] OP_LOAD_B  = 3'd1;
  localparam logic [2:0] OP_LOAD_C  = 3'd2;
  localparam logic [2:0] OP_COMPUTE = 3'd3;
  localparam logic [2:0] OP_READ_C  = 3'd4;

  // Configuration register indexes (byte address divided by four).
  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_INNER = 3'd2;
  localparam logic [2:0] REG_ALPHA = 3'd3;
  localparam logic [2:0] REG_BETA  = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_COL,
    ST_SCALE,
    ST_LOOP,
    ST_TERM,
    ST_ACC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // What one pass of the multiply pipeline does with its element.
  typedef enum logic [1:0] {
    MODE_CLEAR,   // write zero into C
    MODE_SCALE,   // C = beta * C
    MODE_TERM,    // t = alpha * B
    MODE_ACC      // C = C + t * A
  } mode_t;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  a_we;
    logic  b_we;
    logic  c_we;
    addr_t w_addr;
    word_t w_data;
    addr_t a_raddr;
    addr_t b_raddr;
    addr_t c_raddr;
  } mem_req_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
    addr_t c_addr;
  } issue_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    word_t data;
  } wback_t;

  typedef struct packed {
    word_t read_value;
    logic  status;
  } result_t;

  // Column-major element address.
  function automatic addr_t mem_addr(input logic [DIM_W-1:0] row,
                                     input logic [DIM_W-1:0] col);
    return ADDR_W'(row) + ADDR_W'(col) * ADDR_W'(MAX_DIM);
  endfunction

  // Configured size, limited to the store dimension.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
    if (int'(d) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(d);
  endfunction

  // Saturate a sign-extended wide value to one signed word.
  function automatic word_t sat_word(input logic signed [63:0] v);
    if ((&v[63:WORD_W-1]) || !(|v[63:WORD_W-1])) begin
      return v[WORD_W-1:0];
    end
    return v[63] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gmm_if.sv
// ============================================================================
// gmm_if
// Valid/ready channels of the matrix multiply-accumulate core: the request
// channel and the result channel.
// ============================================================================
`default_nettype none

interface gmm_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            op;
  logic [3:0]            row_index;
  logic [3:0]            col_index;
  gmm_pkg::word_t        element_value;

  modport source (output valid, op, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, op, row_index, col_index, element_value,
                  output ready);
endinterface

interface gmm_out_if;
  logic                  valid;
  logic                  ready;
  gmm_pkg::word_t        read_value;
  logic                  status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gmm_store.sv
// ============================================================================
// gmm_store
// Element stores for A, B and C: one write port shared by the three arrays
// and one registered read port per array.
// ============================================================================
`default_nettype none

module gmm_store (
  input  logic              clk,
  input  gmm_pkg::mem_req_t req,
  output gmm_pkg::word_t    a_q,
  output gmm_pkg::word_t    b_q,
  output gmm_pkg::word_t    c_q
);

  gmm_pkg::word_t mem_a [gmm_pkg::STORE_DEPTH];
  gmm_pkg::word_t mem_b [gmm_pkg::STORE_DEPTH];
  gmm_pkg::word_t mem_c [gmm_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.a_we) begin
      mem_a[req.w_addr] <= req.w_data;
    end
    a_q <= mem_a[req.a_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.b_we) begin
      mem_b[req.w_addr] <= req.w_data;
    end
    b_q <= mem_b[req.b_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.c_we) begin
      mem_c[req.w_addr] <= req.w_data;
    end
    c_q <= mem_c[req.c_raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/gmm_qmac.sv
// ============================================================================
// gmm_qmac
// Three-stage Q16.16 multiply, shift-saturate and saturating-add pipeline
// that works on elements read from the stores and writes C back.
// ============================================================================
`default_nettype none

module gmm_qmac (
  input  logic              clk,
  input  logic              rst_n,
  input  gmm_pkg::issue_t   issue,
  input  gmm_pkg::word_t    alpha,
  input  gmm_pkg::word_t    beta,
  input  gmm_pkg::word_t    a_q,
  input  gmm_pkg::word_t    b_q,
  input  gmm_pkg::word_t    c_q,
  output gmm_pkg::wback_t   wback,
  output logic              busy
);

  gmm_pkg::issue_t      s1_r, s2_r, s3_r;
  logic signed [63:0]   prod_r;
  gmm_pkg::word_t       c1_r, c2_r, sat_r, t_r;
  gmm_pkg::word_t       x_op, y_op, add_op;
  logic signed [63:0]   sum_wide;
  gmm_pkg::word_t       sum;

  // Stage one: store data has arrived; pick the factors.
  always_comb begin
    x_op   = '0;
    y_op   = '0;
    add_op = '0;
    case (s1_r.mode)
      gmm_pkg::MODE_SCALE: begin
        x_op = beta;
        y_op = c_q;
      end
      gmm_pkg::MODE_TERM: begin
        x_op = alpha;
        y_op = b_q;
      end
      gmm_pkg::MODE_ACC: begin
        x_op   = t_r;
        y_op   = a_q;
        add_op = c_q;
      end
      default: begin
        x_op = '0;
        y_op = '0;
      end
    endcase
  end

  // Only the valid bits are reset; the rest of each stage simply follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= issue.valid;
      s2_r.valid <= s1_r.valid;
      s3_r.valid <= s2_r.valid;
    end
    s1_r.mode   <= issue.mode;
    s1_r.c_addr <= issue.c_addr;
    s2_r.mode   <= s1_r.mode;
    s2_r.c_addr <= s1_r.c_addr;
    s3_r.mode   <= s2_r.mode;
    s3_r.c_addr <= s2_r.c_addr;
    prod_r      <= x_op * y_op;
    c1_r        <= add_op;
    sat_r       <= gmm_pkg::sat_word(prod_r >>> 16);
    c2_r        <= c1_r;
  end

  // Stage three: the addend is zero outside accumulation, so the sum is the
  // plain scaled product there.
  assign sum_wide = 64'(c2_r) + 64'(sat_r);
  assign sum      = gmm_pkg::sat_word(sum_wide);

  always_ff @(posedge clk) begin
    if (s3_r.valid && (s3_r.mode == gmm_pkg::MODE_TERM)) begin
      t_r <= sum;
    end
  end

  assign wback.we   = s3_r.valid && (s3_r.mode != gmm_pkg::MODE_TERM);
  assign wback.addr = s3_r.c_addr;
  assign wback.data = sum;
  assign busy       = s1_r.valid || s2_r.valid || s3_r.valid;

endmodule

`default_nettype wire

>>> rtl/core/matrix_multiply_accumulate_nn_core.sv
// ============================================================================
// matrix_multiply_accumulate_nn_core
// Fixed-point C = alpha*A*B + beta*C in signed Q16.16, with element loads,
// element reads and a compute request, configured over an APB-style port.
// ============================================================================
//
//   Channel   Dir   Handshake          Carries
//   in_req    in    valid/ready        op, row_index, col_index, element_value
//   out_rsp   out   valid/ready        read_value, status (one per request)
//   cfg_*     in    APB setup/access   sizes m, n, k and alpha, beta
//
// Loads and invalid requests finish in the cycle they are accepted; a read of C
// answers from the registered store read in the ST_READ state. A compute
// request skips the beta pass when beta is one; the sequencer issues one
// element per cycle into the single multiply pipeline and lets it drain
// between passes over a column.
// Reset clears the control state and the registers; the stores are not
// cleared. A stalled result waits in a two-entry result queue.
// ============================================================================
`default_nettype none

module matrix_multiply_accumulate_nn_core (
  input  logic                              clk,
  input  logic                              rst_n,
  gmm_in_if.sink                            in_req,
  gmm_out_if.source                         out_rsp,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gmm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gmm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gmm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [gmm_pkg::CFG_DIM_W-1:0] rows_r, cols_r, inner_r;
  gmm_pkg::word_t                alpha_r, beta_r;
  logic [2:0]                    reg_idx;
  logic                          cfg_wr;

  assign reg_idx    = cfg_paddr[gmm_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= '0;
      cols_r  <= '0;
      inner_r <= '0;
      alpha_r <= gmm_pkg::Q_ONE;
      beta_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gmm_pkg::REG_ROWS:  rows_r  <= cfg_pwdata[gmm_pkg::CFG_DIM_W-1:0];
        gmm_pkg::REG_COLS:  cols_r  <= cfg_pwdata[gmm_pkg::CFG_DIM_W-1:0];
        gmm_pkg::REG_INNER: inner_r <= cfg_pwdata[gmm_pkg::CFG_DIM_W-1:0];
        gmm_pkg::REG_ALPHA: alpha_r <= cfg_pwdata;
        gmm_pkg::REG_BETA:  beta_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gmm_pkg::REG_ROWS:  cfg_prdata = gmm_pkg::CFG_DATA_W'(rows_r);
      gmm_pkg::REG_COLS:  cfg_prdata = gmm_pkg::CFG_DATA_W'(cols_r);
      gmm_pkg::REG_INNER: cfg_prdata = gmm_pkg::CFG_DATA_W'(inner_r);
      gmm_pkg::REG_ALPHA: cfg_prdata = alpha_r;
      gmm_pkg::REG_BETA:  cfg_prdata = beta_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // Sizes in use, limited to the store dimension.
  logic [gmm_pkg::DIM_W-1:0] m_dim, n_dim, k_dim;

  assign m_dim = gmm_pkg::clamp_dim(rows_r);
  assign n_dim = gmm_pkg::clamp_dim(cols_r);
  assign k_dim = gmm_pkg::clamp_dim(inner_r);

  // --------------------------------------------------------------------------
  // Request decode. Each load or read checks its indexes against the
  // configured shape of its own matrix.
  // --------------------------------------------------------------------------
  logic [gmm_pkg::DIM_W-1:0] in_row, in_col;
  gmm_pkg::addr_t            in_addr;
  logic                      in_fire;
  logic                      fit_a, fit_b, fit_c;

  assign in_row  = gmm_pkg::DIM_W'(in_req.row_index);
  assign in_col  = gmm_pkg::DIM_W'(in_req.col_index);
  assign in_addr = gmm_pkg::mem_addr(in_row, in_col);
  assign in_fire = in_req.valid && in_req.ready;
  assign fit_a   = (in_row < m_dim) && (in_col < k_dim);
  assign fit_b   = (in_row < k_dim) && (in_col < n_dim);
  assign fit_c   = (in_row < m_dim) && (in_col < n_dim);

  // --------------------------------------------------------------------------
  // Sequencer. The compute walks column j; per column an optional beta pass
  // over C, then for each inner index l one pass that forms t = alpha*B[l][j]
  // and one pass that adds t*A[i][l] into every C[i][j]. The pipeline drains
  // before the next pass, so a read of C never overtakes its own write-back.
  // --------------------------------------------------------------------------
  gmm_pkg::state_t           state_r, state_nxt, after_r, after_nxt;
  logic [gmm_pkg::DIM_W-1:0] i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;
  gmm_pkg::issue_t           issue;
  gmm_pkg::wback_t           wback;
  gmm_pkg::mem_req_t         mreq;
  gmm_pkg::word_t            a_q, b_q, c_q;
  logic                      pipe_busy;
  logic                      ld_a, ld_b, ld_c;
  logic                      res_push;
  gmm_pkg::result_t          res_data;
  logic                      hold_valid_r;

  assign in_req.ready = (state_r == gmm_pkg::ST_IDLE) && !hold_valid_r;

  always_comb begin
    state_nxt    = state_r;
    after_nxt    = after_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    l_nxt        = l_r;
    issue.valid  = 1'b0;
    issue.mode   = gmm_pkg::MODE_ACC;
    issue.c_addr = gmm_pkg::mem_addr(i_r, j_r);
    ld_a         = 1'b0;
    ld_b         = 1'b0;
    ld_c         = 1'b0;
    res_push     = 1'b0;
    res_data     = '{read_value: '0, status: gmm_pkg::STATUS_OK};

    unique case (state_r)
      gmm_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_req.op)
            gmm_pkg::OP_LOAD_A: begin
              ld_a            = fit_a;
              res_push        = 1'b1;
              res_data.status = fit_a ? gmm_pkg::STATUS_OK : gmm_pkg::STATUS_ERR;
            end
            gmm_pkg::OP_LOAD_B: begin
              ld_b            = fit_b;
              res_push        = 1'b1;
              res_data.status = fit_b ? gmm_pkg::STATUS_OK : gmm_pkg::STATUS_ERR;
            end
            gmm_pkg::OP_LOAD_C: begin
              ld_c            = fit_c;
              res_push        = 1'b1;
              res_data.status = fit_c ? gmm_pkg::STATUS_OK : gmm_pkg::STATUS_ERR;
            end
            gmm_pkg::OP_COMPUTE: begin
              j_nxt     = '0;
              state_nxt = gmm_pkg::ST_COL;
            end
            gmm_pkg::OP_READ_C: begin
              if (fit_c) begin
                state_nxt = gmm_pkg::ST_READ;
              end else begin
                res_push        = 1'b1;
                res_data.status = gmm_pkg::STATUS_ERR;
              end
            end
            default: begin
              res_push        = 1'b1;
              res_data.status = gmm_pkg::STATUS_ERR;
            end
          endcase
        end
      end

      // The store read of C issued at acceptance is on c_q now.
      gmm_pkg::ST_READ: begin
        res_push            = 1'b1;
        res_data.read_value = c_q;
        state_nxt           = gmm_pkg::ST_IDLE;
      end

      gmm_pkg::ST_COL: begin
        if (j_r < n_dim) begin
          i_nxt     = '0;
          l_nxt     = '0;
          state_nxt = (beta_r == gmm_pkg::Q_ONE) ? gmm_pkg::ST_LOOP : gmm_pkg::ST_SCALE;
        end else begin
          state_nxt = gmm_pkg::ST_FINISH;
        end
      end

      // A zero beta clears the column without reading old C.
      gmm_pkg::ST_SCALE: begin
        if (i_r < m_dim) begin
          issue.valid = 1'b1;
          issue.mode  = (beta_r == '0) ? gmm_pkg::MODE_CLEAR : gmm_pkg::MODE_SCALE;
          i_nxt       = i_r + 1'b1;
        end else begin
          after_nxt = gmm_pkg::ST_LOOP;
          state_nxt = gmm_pkg::ST_DRAIN;
        end
      end

      gmm_pkg::ST_LOOP: begin
        if (l_r < k_dim) begin
          state_nxt = gmm_pkg::ST_TERM;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = gmm_pkg::ST_COL;
        end
      end

      gmm_pkg::ST_TERM: begin
        issue.valid = 1'b1;
        issue.mode  = gmm_pkg::MODE_TERM;
        i_nxt       = '0;
        after_nxt   = gmm_pkg::ST_ACC;
        state_nxt   = gmm_pkg::ST_DRAIN;
      end

      gmm_pkg::ST_ACC: begin
        if (i_r < m_dim) begin
          issue.valid = 1'b1;
          issue.mode  = gmm_pkg::MODE_ACC;
          i_nxt       = i_r + 1'b1;
        end else begin
          l_nxt     = l_r + 1'b1;
          after_nxt = gmm_pkg::ST_LOOP;
          state_nxt = gmm_pkg::ST_DRAIN;
        end
      end

      gmm_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = after_r;
        end
      end

      gmm_pkg::ST_FINISH: begin
        res_push  = 1'b1;
        state_nxt = gmm_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = gmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmm_pkg::ST_IDLE;
      after_r <= gmm_pkg::ST_LOOP;
      i_r     <= '0;
      j_r     <= '0;
      l_r     <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      l_r     <= l_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Store access. Loads happen only while idle and write-backs only while
  // computing, so the single write port is never contended.
  // --------------------------------------------------------------------------
  always_comb begin
    mreq.a_raddr = gmm_pkg::mem_addr(i_r, l_r);
    mreq.b_raddr = gmm_pkg::mem_addr(l_r, j_r);
    mreq.c_raddr = (state_r == gmm_pkg::ST_IDLE) ? in_addr : gmm_pkg::mem_addr(i_r, j_r);
    if (wback.we) begin
      mreq.a_we   = 1'b0;
      mreq.b_we   = 1'b0;
      mreq.c_we   = 1'b1;
      mreq.w_addr = wback.addr;
      mreq.w_data = wback.data;
    end else begin
      mreq.a_we   = ld_a;
      mreq.b_we   = ld_b;
      mreq.c_we   = ld_c;
      mreq.w_addr = in_addr;
      mreq.w_data = in_req.element_value;
    end
  end

  gmm_store u_store (
    .clk (clk),
    .req (mreq),
    .a_q (a_q),
    .b_q (b_q),
    .c_q (c_q)
  );

  gmm_qmac u_qmac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .alpha (alpha_r),
    .beta  (beta_r),
    .a_q   (a_q),
    .b_q   (b_q),
    .c_q   (c_q),
    .wback (wback),
    .busy  (pipe_busy)
  );

  // --------------------------------------------------------------------------
  // Result queue: the output register plus one holding entry. A request is
  // only accepted while the holding entry is empty, so every result has room.
  // --------------------------------------------------------------------------
  logic             out_valid_r, out_valid_nxt, hold_valid_nxt;
  gmm_pkg::result_t out_data_r, out_data_nxt, hold_data_r, hold_data_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    if (out_free) begin
      if (hold_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = hold_data_r;
        hold_valid_nxt = res_push;
        hold_data_nxt  = res_data;
      end else begin
        out_valid_nxt = res_push;
        out_data_nxt  = res_data;
      end
    end else if (res_push) begin
      hold_valid_nxt = 1'b1;
      hold_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.read_value = out_data_r.read_value;
  assign out_rsp.status     = out_data_r.status;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate core regression bench
// Loads A, B and C element by element, starts computations and reads C back
// under several size and alpha/beta settings, with random idling on both
// channels. Every result is checked against an in-bench Q16.16 predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gmm_pkg::*;

  // Opcodes outside the defined set; the core must reject them.
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  // Cycles with no request and no result accepted before the run is declared
  // hung. The limit lies far beyond the slowest compute used here and the long
  // receiver hold-off.
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 400;
  localparam int PRINT_CAP   = 30;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] row;
    logic [3:0] col;
    word_t      value;
  } request_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gmm_in_if  in_bus ();
  gmm_out_if out_bus ();

  matrix_multiply_accumulate_nn_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_bus),
    .out_rsp     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the three element stores and the register file as the
  // core should hold them. The stores are laid out by column, row + col*16.
  // --------------------------------------------------------------------------
  word_t      a_elem [STORE_DEPTH] = '{default: '0};
  word_t      b_elem [STORE_DEPTH] = '{default: '0};
  word_t      c_elem [STORE_DEPTH] = '{default: '0};
  logic [4:0] rows_reg  = '0;
  logic [4:0] cols_reg  = '0;
  logic [4:0] inner_reg = '0;
  word_t      alpha_q   = Q_ONE;
  word_t      beta_q    = '0;

  // Requests waiting to be offered, and results still owed by the core.
  request_t queued_requests [$];
  result_t  awaited_results [$];

  // Stimulus-side bookkeeping. The stores are undefined until written, so the
  // generator remembers which elements have been given a value and never
  // issues a read or a compute that would touch any other element.
  bit    a_loaded [STORE_DEPTH];
  bit    b_loaded [STORE_DEPTH];
  bit    c_loaded [STORE_DEPTH];
  int    gen_m, gen_n, gen_k;
  int    queued_total;

  int       mismatches;
  int       results_seen;
  int       quiet_cycles;
  int       send_gap;
  int       stall_left;
  int       hold_left;
  logic     hold_go;
  logic     calm;
  request_t offered;

  // --------------------------------------------------------------------------
  // Q16.16 arithmetic as the core defines it.
  // --------------------------------------------------------------------------
  function automatic word_t clip_word(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < 64'shFFFF_FFFF_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // The exact product is shifted arithmetically, which truncates toward minus
  // infinity, and only then saturated.
  function automatic word_t q_mul(input word_t x, input word_t y);
    logic signed [63:0] p;
    p = x * y;
    return clip_word(p >>> 16);
  endfunction

  function automatic word_t q_add(input word_t x, input word_t y);
    logic signed [63:0] s;
    s = x + y;
    return clip_word(s);
  endfunction

  // Sizes above the store dimension behave as the store dimension.
  function automatic int eff_size(input logic [4:0] d);
    return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // C = alpha*A*B + beta*C, walked column by column: clear or scale the
  // column first, then accumulate one inner index at a time.
  function automatic void multiply_accumulate();
    int    m, n, k;
    word_t t;
    m = eff_size(rows_reg);
    n = eff_size(cols_reg);
    k = eff_size(inner_reg);
    for (int j = 0; j < n; j++) begin
      if (beta_q == 0) begin
        for (int i = 0; i < m; i++) c_elem[i + j * MAX_DIM] = '0;
      end else if (beta_q != Q_ONE) begin
        for (int i = 0; i < m; i++) begin
          c_elem[i + j * MAX_DIM] = q_mul(beta_q, c_elem[i + j * MAX_DIM]);
        end
      end
      for (int l = 0; l < k; l++) begin
        t = q_mul(alpha_q, b_elem[l + j * MAX_DIM]);
        for (int i = 0; i < m; i++) begin
          c_elem[i + j * MAX_DIM] =
            q_add(c_elem[i + j * MAX_DIM], q_mul(t, a_elem[i + l * MAX_DIM]));
        end
      end
    end
  endfunction

  // Apply one accepted request to the predicted state and return the result
  // the core owes for it. Out-of-range indices and unknown opcodes leave the
  // state untouched and report an error with a zero value.
  function automatic result_t exec_request(input request_t r);
    result_t res;
    int      m, n, k, row, col, at;
    m   = eff_size(rows_reg);
    n   = eff_size(cols_reg);
    k   = eff_size(inner_reg);
    row = int'(r.row);
    col = int'(r.col);
    at  = row + col * MAX_DIM;
    res.read_value = '0;
    res.status     = STATUS_OK;
    case (r.op)
      OP_LOAD_A: begin
        if (row < m && col < k) a_elem[at] = r.value;
        else res.status = STATUS_ERR;
      end
      OP_LOAD_B: begin
        if (row < k && col < n) b_elem[at] = r.value;
        else res.status = STATUS_ERR;
      end
      OP_LOAD_C: begin
        if (row < m && col < n) c_elem[at] = r.value;
        else res.status = STATUS_ERR;
      end
      OP_COMPUTE: begin
        multiply_accumulate();
      end
      OP_READ_C: begin
        if (row < m && col < n) res.read_value = c_elem[at];
        else res.status = STATUS_ERR;
      end
      default: begin
        res.status = STATUS_ERR;
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation.
  // --------------------------------------------------------------------------

  // Element values: the two extremes, full-range noise, and values within
  // about two in Q16.16 so that plenty of results stay clear of saturation.
  function automatic word_t rand_elem();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return word_t'($urandom);
      default: return word_t'($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    endcase
  endfunction

  // Scale factors, with one, minus one and zero weighted up since the core
  // treats beta zero and beta one specially.
  function automatic word_t rand_scale();
    case ($urandom_range(0, 6))
      0:       return Q_ONE;
      1:       return -Q_ONE;
      2:       return '0;
      3:       return word_t'($urandom);
      default: return word_t'($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    endcase
  endfunction

  // Mostly small sizes; now and then empty or mid-sized.
  function automatic int rand_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(5, 8);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // Queue a request and record which elements it gives a value. The sizes
  // used here are the ones in force when the request will be accepted, since
  // the registers only change while nothing is queued.
  function automatic void queue_req(input logic [2:0] op, input int row, input int col,
                                    input word_t value);
    request_t r;
    int       at;
    r.op    = op;
    r.row   = 4'(row);
    r.col   = 4'(col);
    r.value = value;
    at      = row + col * MAX_DIM;
    case (op)
      OP_LOAD_A: if (row < gen_m && col < gen_k) a_loaded[at] = 1'b1;
      OP_LOAD_B: if (row < gen_k && col < gen_n) b_loaded[at] = 1'b1;
      OP_LOAD_C: if (row < gen_m && col < gen_n) c_loaded[at] = 1'b1;
      OP_COMPUTE: begin
        for (int j = 0; j < gen_n; j++) begin
          for (int i = 0; i < gen_m; i++) c_loaded[i + j * MAX_DIM] = 1'b1;
        end
      end
      default: ;
    endcase
    queued_requests.push_back(r);
    queued_total++;
  endfunction

  // True when a compute would only touch elements that hold a value. Old C
  // is only read when beta is not zero.
  function automatic bit operands_ready();
    for (int l = 0; l < gen_k; l++) begin
      for (int i = 0; i < gen_m; i++) if (!a_loaded[i + l * MAX_DIM]) return 1'b0;
      for (int j = 0; j < gen_n; j++) if (!b_loaded[l + j * MAX_DIM]) return 1'b0;
    end
    if (beta_q != 0) begin
      for (int j = 0; j < gen_n; j++) begin
        for (int i = 0; i < gen_m; i++) if (!c_loaded[i + j * MAX_DIM]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // A random request of any opcode and any index. A read or compute that
  // would touch an unwritten element is turned into a load instead.
  function automatic void queue_noise();
    logic [2:0] op;
    int         row, col;
    op  = 3'($urandom_range(0, 7));
    row = $urandom_range(0, 15);
    col = $urandom_range(0, 15);
    if (op == OP_READ_C && row < gen_m && col < gen_n && !c_loaded[row + col * MAX_DIM]) begin
      op = OP_LOAD_C;
    end
    if (op == OP_COMPUTE && !operands_ready()) begin
      op = OP_LOAD_A;
    end
    queue_req(op, row, col, rand_elem());
  endfunction

  function automatic void sprinkle_noise();
    if ($urandom_range(0, 9) == 0) queue_noise();
  endfunction

  // Reads of C after a compute. With an empty C every read is out of range.
  function automatic void queue_reads(input int count);
    for (int r = 0; r < count; r++) begin
      sprinkle_noise();
      if (gen_m == 0 || gen_n == 0) begin
        queue_req(OP_READ_C, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
      end else begin
        queue_req(OP_READ_C, $urandom_range(0, gen_m - 1), $urandom_range(0, gen_n - 1),
                  rand_elem());
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sequencing helpers for the main thread.
  // --------------------------------------------------------------------------

  // Wait until every queued request has been accepted and every result has
  // come back. Each request yields exactly one result, so the core is idle
  // then; a few extra cycles are left for good measure.
  task automatic wait_idle();
    while (queued_requests.size() != 0 || in_bus.valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // One APB write: a setup phase, then an access phase that completes when
  // pready is high. The predictor's copy is updated once the write is done.
  task automatic cfg_write(input logic [2:0] reg_idx, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (reg_idx)
      REG_ROWS:  rows_reg  = data[4:0];
      REG_COLS:  cols_reg  = data[4:0];
      REG_INNER: inner_reg = data[4:0];
      REG_ALPHA: alpha_q   = word_t'(data);
      REG_BETA:  beta_q    = word_t'(data);
      default: ;
    endcase
  endtask

  // Reprogram every register once the core has gone idle.
  task automatic set_geometry(input int rows, input int cols, input int inner,
                              input word_t alpha, input word_t beta);
    wait_idle();
    cfg_write(REG_ROWS, 32'(rows));
    cfg_write(REG_COLS, 32'(cols));
    cfg_write(REG_INNER, 32'(inner));
    cfg_write(REG_ALPHA, alpha);
    cfg_write(REG_BETA, beta);
    gen_m = eff_size(rows_reg);
    gen_n = eff_size(cols_reg);
    gen_k = eff_size(inner_reg);
  endtask

  // A well-formed pass: fresh A and B, C when beta needs it (sometimes also
  // when beta would clear it), a compute, reads of the result, and now and
  // then a second compute that accumulates onto the first.
  task automatic run_phase(input int rows, input int cols, input int inner,
                           input word_t alpha, input word_t beta, input int reads);
    bit fill_c;
    set_geometry(rows, cols, inner, alpha, beta);
    @(negedge clk);
    for (int l = 0; l < gen_k; l++) begin
      for (int i = 0; i < gen_m; i++) begin
        sprinkle_noise();
        queue_req(OP_LOAD_A, i, l, rand_elem());
      end
    end
    for (int j = 0; j < gen_n; j++) begin
      for (int l = 0; l < gen_k; l++) begin
        sprinkle_noise();
        queue_req(OP_LOAD_B, l, j, rand_elem());
      end
    end
    fill_c = (beta != 0) || (gen_m * gen_n <= 16 && $urandom_range(0, 1) == 1);
    if (fill_c) begin
      for (int j = 0; j < gen_n; j++) begin
        for (int i = 0; i < gen_m; i++) begin
          sprinkle_noise();
          queue_req(OP_LOAD_C, i, j, rand_elem());
        end
      end
    end
    queue_req(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
    queue_reads(reads);
    if (beta != 0 && $urandom_range(0, 1) == 1) begin
      queue_req(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
      queue_reads(reads / 2 + 1);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t: result %0d %s mismatch: got %h, expected %h",
               $realtime, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver. A request stays on the bus until it is accepted; only
  // then may the next one go out or an idle burst begin. The predictor runs
  // at the acceptance edge, so its order matches the core's exactly.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        awaited_results.push_back(exec_request(offered));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (queued_requests.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          // This cycle idles and starts a random idle gap.
          send_gap = $urandom_range(0, 6);
          in_bus.valid <= 1'b0;
        end else begin
          offered = queued_requests.pop_front();
          in_bus.op            <= offered.op;
          in_bus.row_index     <= offered.row;
          in_bus.col_index     <= offered.col;
          in_bus.element_value <= offered.value;
          in_bus.valid         <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. Short random stalls, plus one long hold-off on request
  // from the main thread, which lets the core's result queue fill and forces
  // it to push back on the request channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_go) begin
      hold_left = LONG_HOLD - 1;
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted result is matched against the oldest
  // expectation, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected", out_bus.read_value, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_bus.read_value !== want.read_value) begin
          report_mismatch("read_value", out_bus.read_value, want.read_value);
        end
        if (out_bus.status !== want.status) begin
          report_mismatch("status", 32'(out_bus.status), 32'(want.status));
        end
      end
    end
  end

  // Watchdog: too long without any request or result moving means a hang.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main thread: reset, directed requests, special settings, random phases,
  // then a final stretch without idling.
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    in_bus.valid         = 1'b0;
    in_bus.op            = OP_LOAD_A;
    in_bus.row_index     = '0;
    in_bus.col_index     = '0;
    in_bus.element_value = '0;
    out_bus.ready        = 1'b0;
    hold_go              = 1'b0;
    calm                 = 1'b0;
    mismatches           = 0;
    results_seen         = 0;
    quiet_cycles         = 0;
    send_gap             = 0;
    stall_left           = 0;
    hold_left            = 0;
    queued_total         = 0;
    gen_m                = 0;
    gen_n                = 0;
    gen_k                = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset sizes all zero, every load and read is out of range,
    // unknown opcodes are rejected, and a compute has nothing to do.
    @(negedge clk);
    for (int b = OP_BAD_FIRST; b <= OP_BAD_LAST; b++) begin
      queue_req(3'(b), 15, 15, 32'sh7FFF_FFFF);
    end
    queue_req(OP_LOAD_A, 0, 0, 32'sh0001_0000);
    queue_req(OP_LOAD_B, 0, 0, 32'sh0001_0000);
    queue_req(OP_LOAD_C, 0, 0, 32'sh0001_0000);
    queue_req(OP_READ_C, 0, 0, '0);
    queue_req(OP_COMPUTE, 0, 0, '0);

    // A two-by-one product built from the extreme values, so that C saturates
    // at both ends, plus loads and reads just past each configured size.
    set_geometry(2, 1, 1, Q_ONE, '0);
    @(negedge clk);
    queue_req(OP_LOAD_A, 0, 0, 32'sh7FFF_FFFF);
    queue_req(OP_LOAD_A, 1, 0, 32'sh8000_0000);
    queue_req(OP_LOAD_B, 0, 0, 32'sh7FFF_FFFF);
    queue_req(OP_LOAD_A, 2, 0, rand_elem());
    queue_req(OP_LOAD_A, 0, 1, rand_elem());
    queue_req(OP_LOAD_B, 1, 0, rand_elem());
    queue_req(OP_LOAD_B, 0, 1, rand_elem());
    queue_req(OP_LOAD_C, 0, 1, rand_elem());
    queue_req(OP_COMPUTE, 0, 0, '0);
    queue_req(OP_READ_C, 0, 0, '0);
    queue_req(OP_READ_C, 1, 0, '0);
    queue_req(OP_READ_C, 2, 0, '0);
    queue_req(OP_READ_C, 15, 15, '0);
    queue_req(OP_BAD_LAST, 0, 0, '0);

    // Rows above the store size, with beta one so scaling is skipped.
    run_phase(31, 2, 3, rand_scale(), Q_ONE, 12);
    // Sixteen columns, alpha at its top, beta minus one. While this phase is
    // still feeding requests the receiver holds off for a long stretch.
    run_phase(2, 16, 2, 32'sh7FFF_FFFF, -Q_ONE, 12);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    // Full inner size, alpha at its bottom, beta one half.
    run_phase(3, 2, 16, 32'sh8000_0000, 32'sh0000_8000, 8);
    // Inner size above the store size, beta at its top.
    run_phase(1, 1, 31, rand_scale(), 32'sh7FFF_FFFF, 2);
    // Full row count with too many columns; beta zero clears C.
    run_phase(16, 31, 1, rand_scale(), '0, 24);
    // No inner work: only the beta step, with beta at its bottom.
    run_phase(2, 2, 0, rand_scale(), 32'sh8000_0000, 4);
    // No columns, then no rows; alpha zero in the second.
    run_phase(3, 0, 2, rand_scale(), rand_scale(), 3);
    run_phase(0, 2, 2, '0, rand_scale(), 3);

    while (queued_total < 1000) begin
      run_phase(rand_dim(), rand_dim(), rand_dim(), rand_scale(), rand_scale(),
                $urandom_range(2, 10));
    end

    // The last stretch runs with both sides always willing.
    wait_idle();
    @(posedge clk);
    calm <= 1'b1;
    repeat (3) begin
      run_phase(rand_dim(), rand_dim(), rand_dim(), rand_scale(), rand_scale(),
                $urandom_range(2, 10));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch("missing", '0, 32'(awaited_results.size()));
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
